### design/rhcc_pkg.sv
`default_nettype none

package rhcc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int CW        = FRAC_BITS + 1;      // channel, saturation and brightness
    localparam int HW        = FRAC_BITS + 9;      // hue in degrees times 2^16 (unsigned Q9.16)
    localparam int QW        = FRAC_BITS + 3;      // quotient bits, one per division cell
    localparam int NW        = 2 * FRAC_BITS + 1;  // dividend width
    localparam int SW        = 3;                  // sector number
    localparam int HSW       = FRAC_BITS + 5;      // signed hue before scaling by sixty
    localparam int SECTOR_DEG = 60;

    localparam logic [CW-1:0] UNITY     = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [HW-1:0] HUE_FULL  = HW'(360) << FRAC_BITS;
    localparam logic [CW-1:0] DEN_SIXTY = CW'(SECTOR_DEG);

    typedef enum logic {
        CMD_TO_HSV = 1'b0,
        CMD_TO_RGB = 1'b1
    } cmd_e;

    typedef enum logic [SW-1:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } sec_e;

    typedef struct packed {
        logic          command;
        logic [CW-1:0] red;
        logic [CW-1:0] green;
        logic [CW-1:0] blue;
        logic [HW-1:0] hue;
        logic [CW-1:0] saturation;
        logic [CW-1:0] brightness;
    } pixel_t;

    typedef struct packed {
        logic [CW-1:0] out_red;
        logic [CW-1:0] out_green;
        logic [CW-1:0] out_blue;
        logic [HW-1:0] out_hue;
        logic [CW-1:0] out_saturation;
        logic [CW-1:0] out_brightness;
    } result_t;

    // Partial state of one restoring division.
    typedef struct packed {
        logic [CW-1:0] rem;
        logic [NW-1:0] num;
        logic [CW-1:0] den;
        logic [QW-1:0] quo;
    } div_t;

    // Per-pixel context that travels alongside the divisions.
    typedef struct packed {
        cmd_e          cmd;
        sec_e          sector;
        logic          neg;
        logic          flat;
        logic          grey;
        logic [CW-1:0] val;
        logic [CW-1:0] sat;
    } ctx_t;

    // The quotient is known to stay below 2^QW, so the top bits of the
    // dividend can be loaded straight into the remainder.
    function automatic div_t div_init(input logic [NW-1:0] n, input logic [CW-1:0] den);
        div_t r;
        r.rem = CW'(n[NW-1:QW]);
        r.num = {n[QW-1:0], {(NW-QW){1'b0}}};
        r.den = den;
        r.quo = '0;
        return r;
    endfunction

    function automatic div_t div_step(input div_t d);
        logic [CW:0] cur;
        logic [CW:0] trial;
        logic        ge;
        div_t        r;
        cur   = {d.rem, d.num[NW-1]};
        trial = cur - {1'b0, d.den};
        ge    = (cur >= {1'b0, d.den});
        r.rem = ge ? trial[CW-1:0] : cur[CW-1:0];
        r.num = {d.num[NW-2:0], 1'b0};
        r.den = d.den;
        r.quo = {d.quo[QW-2:0], ge};
        return r;
    endfunction

    function automatic logic [CW-1:0] fmul(input logic [CW-1:0] a, input logic [CW-1:0] b);
        logic [2*CW-1:0] m;
        m = {{CW{1'b0}}, a} * {{CW{1'b0}}, b};
        return m[FRAC_BITS+CW-1:FRAC_BITS];
    endfunction

endpackage

`default_nettype wire

### design/rgb_hsv_color_converter.sv
`default_nettype none

// Fixed-point colour converter between RGB and HSV, chosen per pixel by the
// command field. It takes one pixel request per clock while pixel_stall is low
// and delivers results in order. A request passes through one input stage, a
// row of 19 restoring-division cells that each retire one quotient bit (for
// delta over max and for the hue fraction, or for hue over sixty), and two
// multiply stages for the hue scaling and the p, q and t products. A skid entry
// at the output keeps the pipeline moving while the consumer stalls until a
// second result is waiting; pixel_stall then stays high until the result on
// the output is taken.
module rgb_hsv_color_converter
    import rhcc_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   pixel_valid,
    output logic        pixel_stall,
    input  wire pixel_t pixel,
    output logic        result_valid,
    input  wire logic   result_stall,
    output result_t     result
);

    logic            en;
    logic            hold;
    logic [QW+1:0]   vld_reg;
    ctx_t            cell_ctx [QW+1];
    div_t            cell_a   [QW+1];
    div_t            cell_b   [QW+1];

    assign en          = !hold;
    assign pixel_stall = hold;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[QW:0], pixel_valid};
    end

    rhcc_prep u_prep (
        .clk   (clk),
        .en    (en),
        .pixel (pixel),
        .ctx   (cell_ctx[0]),
        .div_a (cell_a[0]),
        .div_b (cell_b[0])
    );

    for (genvar g = 0; g < QW; g++)
    begin : g_cell
        rhcc_cell u_cell (
            .clk    (clk),
            .en     (en),
            .ctx_in (cell_ctx[g]),
            .a_in   (cell_a[g]),
            .b_in   (cell_b[g]),
            .ctx    (cell_ctx[g+1]),
            .a      (cell_a[g+1]),
            .b      (cell_b[g+1])
        );
    end

    rhcc_post u_post (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .ctx_in       (cell_ctx[QW]),
        .qa           (cell_a[QW].quo),
        .qb           (cell_b[QW].quo),
        .p1_valid     (vld_reg[QW+1]),
        .result_stall (result_stall),
        .result       (result),
        .result_valid (result_valid),
        .hold         (hold)
    );

`ifndef SYNTHESIS
    a_hold_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_stall |-> result_valid)
        else $error("skid entry full without a result on the output");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_stall && result_valid && !result_stall) |=> !pixel_stall)
        else $error("skid entry did not drain after the result was taken");

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.out_hue < HUE_FULL))
        else $error("hue result out of range");

    a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.out_saturation <= UNITY))
        else $error("saturation result above one");
`endif

endmodule

`default_nettype wire

### design/rhcc_prep.sv
`default_nettype none

module rhcc_prep
    import rhcc_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   en,
    input  wire pixel_t pixel,
    output ctx_t        ctx,
    output div_t        div_a,
    output div_t        div_b
);

    logic [CW-1:0] mx_rg;
    logic [CW-1:0] mn_rg;
    logic [CW-1:0] mx;
    logic [CW-1:0] mn;
    logic [CW-1:0] delta;
    logic [CW-1:0] hi_c;
    logic [CW-1:0] lo_c;
    logic [CW-1:0] mag;
    logic [HW-1:0] hue_c;
    sec_e          sector;
    logic          neg;
    ctx_t          ctx_next;
    div_t          a_next;
    div_t          b_next;

    always_comb
    begin
        mx_rg = (pixel.red > pixel.green) ? pixel.red : pixel.green;
        mn_rg = (pixel.red < pixel.green) ? pixel.red : pixel.green;
        mx    = (mx_rg > pixel.blue) ? mx_rg : pixel.blue;
        mn    = (mn_rg < pixel.blue) ? mn_rg : pixel.blue;
        delta = mx - mn;

        // Ties go to red first, then green.
        if (pixel.red >= mx)
        begin
            sector = SEC_RED_YEL;
            hi_c   = pixel.green;
            lo_c   = pixel.blue;
        end
        else if (pixel.green >= mx)
        begin
            sector = SEC_GRN_CYN;
            hi_c   = pixel.blue;
            lo_c   = pixel.red;
        end
        else
        begin
            sector = SEC_BLU_MAG;
            hi_c   = pixel.red;
            lo_c   = pixel.green;
        end
        neg = (hi_c < lo_c);
        mag = neg ? (lo_c - hi_c) : (hi_c - lo_c);

        hue_c = (pixel.hue >= HUE_FULL) ? '0 : pixel.hue;

        ctx_next.cmd    = cmd_e'(pixel.command);
        ctx_next.sector = sector;
        ctx_next.neg    = neg;
        ctx_next.flat   = (delta == '0);
        ctx_next.grey   = (pixel.saturation == '0);
        ctx_next.sat    = (pixel.saturation > UNITY) ? UNITY : pixel.saturation;

        if (cmd_e'(pixel.command) == CMD_TO_RGB)
        begin
            ctx_next.val = pixel.brightness;
            a_next       = div_init(NW'(hue_c), DEN_SIXTY);
            b_next       = div_init('0, DEN_SIXTY);
        end
        else
        begin
            ctx_next.val = mx;
            a_next       = div_init({delta, {FRAC_BITS{1'b0}}}, mx);
            b_next       = div_init({mag, {FRAC_BITS{1'b0}}}, delta);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx   <= ctx_next;
            div_a <= a_next;
            div_b <= b_next;
        end
    end

endmodule

`default_nettype wire

### design/rhcc_cell.sv
`default_nettype none

module rhcc_cell
    import rhcc_pkg::*;
(
    input  wire logic clk,
    input  wire logic en,
    input  wire ctx_t ctx_in,
    input  wire div_t a_in,
    input  wire div_t b_in,
    output ctx_t      ctx,
    output div_t      a,
    output div_t      b
);

    // One quotient bit of each division per cell.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx <= ctx_in;
            a   <= div_step(a_in);
            b   <= div_step(b_in);
        end
    end

endmodule

`default_nettype wire

### design/rhcc_post.sv
`default_nettype none

module rhcc_post
    import rhcc_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire ctx_t          ctx_in,
    input  wire logic [QW-1:0] qa,
    input  wire logic [QW-1:0] qb,
    input  wire logic          p1_valid,
    input  wire logic          result_stall,
    output result_t            result,
    output logic               result_valid,
    output logic               hold
);

    logic [SW+FRAC_BITS-1:0] base;
    logic signed [HSW-1:0]   hs;
    logic signed [HSW+5:0]   hm;
    logic signed [HSW+5:0]   hw;
    logic [FRAC_BITS-1:0]    ff;

    logic [HW-1:0] hue_next;
    logic [CW-1:0] sat_next;
    logic [CW-1:0] p_next;
    logic [CW-1:0] sf_next;
    logic [CW-1:0] s1_next;

    cmd_e          cmd_reg;
    logic          grey_reg;
    logic [CW-1:0] val_reg;
    logic [SW-1:0] sec_reg;
    logic [HW-1:0] hue_reg;
    logic [CW-1:0] sat_reg;
    logic [CW-1:0] p_reg;
    logic [CW-1:0] sf_reg;
    logic [CW-1:0] s1_reg;

    logic [CW-1:0] q;
    logic [CW-1:0] t;
    logic [CW-1:0] r_c;
    logic [CW-1:0] g_c;
    logic [CW-1:0] b_c;
    result_t       res_next;

    result_t t_reg;
    result_t s_reg;
    logic    t_vld_reg;
    logic    s_vld_reg;

    always_comb
    begin
        base = {ctx_in.sector, {FRAC_BITS{1'b0}}};
        if (ctx_in.neg)
            hs = $signed({2'b00, base}) - $signed({2'b00, qb});
        else
            hs = $signed({2'b00, base}) + $signed({2'b00, qb});
        hm = $signed({{6{hs[HSW-1]}}, hs}) * $signed((HSW+6)'(SECTOR_DEG));
        hw = hm[HSW+5] ? (hm + $signed((HSW+6)'(HUE_FULL))) : hm;

        hue_next = ctx_in.flat ? '0 : hw[HW-1:0];
        sat_next = ctx_in.flat ? '0 : qa[CW-1:0];

        ff      = qa[FRAC_BITS-1:0];
        sf_next = fmul(ctx_in.sat, {1'b0, ff});
        s1_next = fmul(ctx_in.sat, UNITY - {1'b0, ff});
        p_next  = fmul(ctx_in.val, UNITY - ctx_in.sat);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cmd_reg  <= ctx_in.cmd;
            grey_reg <= ctx_in.grey;
            val_reg  <= ctx_in.val;
            sec_reg  <= qa[QW-1:FRAC_BITS];
            hue_reg  <= hue_next;
            sat_reg  <= sat_next;
            p_reg    <= p_next;
            sf_reg   <= sf_next;
            s1_reg   <= s1_next;
        end
    end

    always_comb
    begin
        q = fmul(val_reg, UNITY - sf_reg);
        t = fmul(val_reg, UNITY - s1_reg);
        case (sec_reg)
            SEC_RED_YEL: begin r_c = val_reg; g_c = t;       b_c = p_reg;   end
            SEC_YEL_GRN: begin r_c = q;       g_c = val_reg; b_c = p_reg;   end
            SEC_GRN_CYN: begin r_c = p_reg;   g_c = val_reg; b_c = t;       end
            SEC_CYN_BLU: begin r_c = p_reg;   g_c = q;       b_c = val_reg; end
            SEC_BLU_MAG: begin r_c = t;       g_c = p_reg;   b_c = val_reg; end
            default:     begin r_c = val_reg; g_c = p_reg;   b_c = q;       end
        endcase
        if (grey_reg)
        begin
            r_c = val_reg;
            g_c = val_reg;
            b_c = val_reg;
        end

        res_next = '0;
        if (cmd_reg == CMD_TO_RGB)
        begin
            res_next.out_red   = r_c;
            res_next.out_green = g_c;
            res_next.out_blue  = b_c;
        end
        else
        begin
            res_next.out_hue        = hue_reg;
            res_next.out_saturation = sat_reg;
            res_next.out_brightness = val_reg;
        end
    end

    // Output register with a skid entry behind it, so the pipeline keeps
    // moving while the consumer stalls until a second result is waiting.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_vld_reg <= 1'b0;
            s_vld_reg <= 1'b0;
        end
        else if (!t_vld_reg || !result_stall)
        begin
            t_vld_reg <= s_vld_reg || (en && p1_valid);
            s_vld_reg <= 1'b0;
        end
        else if (en && p1_valid)
        begin
            s_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!t_vld_reg || !result_stall)
        begin
            if (s_vld_reg)
                t_reg <= s_reg;
            else if (en)
                t_reg <= res_next;
        end
        else if (en && p1_valid)
        begin
            s_reg <= res_next;
        end
    end

    assign result       = t_reg;
    assign result_valid = t_vld_reg;
    assign hold         = s_vld_reg;

endmodule

`default_nettype wire
